// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and constants for the register access sequencer and its top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int unsigned RECOVERY_CLOCKS = 9;

   localparam logic [15:0] GAP_TICKS_RESET = 16'd10000;

   localparam logic [1:0] ACTION_WRITE = 2'd1;
   localparam logic [1:0] ACTION_READ  = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_ACK     = 2'd1;
   localparam logic [1:0] STATUS_START_FAIL = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE          = 5'd0,
      ST_START_PREP    = 5'd1,
      ST_START_CHECK   = 5'd2,
      ST_RECOVER       = 5'd3,
      ST_RECOVER_CHECK = 5'd4,
      ST_SDA_LOW       = 5'd5,
      ST_SCL_LOW       = 5'd6,
      ST_START_VERIFY  = 5'd7,
      ST_ADDR_W        = 5'd8,
      ST_REG           = 5'd9,
      ST_LOAD          = 5'd10,
      ST_GAP           = 5'd11,
      ST_DATA          = 5'd12,
      ST_ADDR_R        = 5'd13,
      ST_RECEIVE       = 5'd14,
      ST_STOP          = 5'd15
   } seq_state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_level;
   } tick_item_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       byte_request;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } tick_result_type;

endpackage

`default_nettype wire

// ----- rtl/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// I2C master register access sequencer
// Holds the bus sequencing state and advances it by one phase for each tick
// item, producing the result of that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire i2cm_pkg::tick_item_type   item,
   input  wire logic [15:0]               gap_ticks,
   output      i2cm_pkg::tick_result_type result
);
   import i2cm_pkg::*;

   seq_state_type state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [3:0]    bit_ff, bit_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    left_ff, left_in;
   logic [15:0]   gap_ff, gap_in;
   logic [6:0]    device_ff, device_in;
   logic [7:0]    register_ff, register_in;
   logic          is_read_ff, is_read_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic [1:0]    pending_ff, pending_in;
   logic          restart_ff, restart_in;

   logic          req;
   logic          rvalid;
   logic [7:0]    rbyte;
   logic          done;
   logic [1:0]    status;
   logic          ack_done;
   logic [7:0]    left_dec;
   logic [7:0]    shift_rx;
   logic [3:0]    bit_inc;
   logic [15:0]   gap_dec;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      left_in     = left_ff;
      gap_in      = gap_ff;
      device_in   = device_ff;
      register_in = register_ff;
      is_read_in  = is_read_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      pending_in  = pending_ff;
      restart_in  = restart_ff;
      req         = 1'b0;
      rvalid      = 1'b0;
      rbyte       = 8'd0;
      done        = 1'b0;
      status      = STATUS_OK;
      ack_done    = 1'b0;
      left_dec    = left_ff - 8'd1;
      shift_rx    = {shift_ff[6:0], item.sda_level};
      bit_inc     = bit_ff + 4'd1;
      gap_dec     = (gap_ff != 16'd0) ? gap_ff - 16'd1 : gap_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item.action == ACTION_WRITE || item.action == ACTION_READ) begin
               device_in   = item.device_address;
               register_in = item.register_address;
               left_in     = item.byte_count;
               is_read_in  = (item.action == ACTION_READ);
               restart_in  = 1'b0;
               pending_in  = STATUS_OK;
               scl_in      = 1'b1;
               sda_in      = 1'b1;
               state_in    = ST_START_CHECK;
            end
         end
         ST_START_PREP: begin
            scl_in   = 1'b1;
            sda_in   = 1'b1;
            state_in = ST_START_CHECK;
         end
         ST_START_CHECK: begin
            if (!item.sda_level) begin
               bit_in   = 4'd0;
               phase_in = 2'd0;
               state_in = ST_RECOVER;
            end else begin
               state_in = ST_SDA_LOW;
            end
         end
         ST_RECOVER: begin
            if (phase_ff == 2'd0) begin
               scl_in   = 1'b0;
               phase_in = 2'd1;
            end else begin
               scl_in   = 1'b1;
               phase_in = 2'd0;
               if (bit_ff >= 4'(RECOVERY_CLOCKS - 1)) begin
                  bit_in   = 4'd0;
                  state_in = ST_RECOVER_CHECK;
               end else begin
                  bit_in = bit_inc;
               end
            end
         end
         ST_RECOVER_CHECK: begin
            if (!item.sda_level) begin
               done     = 1'b1;
               status   = STATUS_NO_ACK;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SDA_LOW;
            end
         end
         ST_SDA_LOW: begin
            sda_in   = 1'b0;
            state_in = ST_SCL_LOW;
         end
         ST_SCL_LOW: begin
            scl_in   = 1'b0;
            state_in = ST_START_VERIFY;
         end
         ST_START_VERIFY: begin
            if (item.sda_level) begin
               done     = 1'b1;
               status   = STATUS_START_FAIL;
               state_in = ST_IDLE;
            end else begin
               shift_in = restart_ff ? {device_ff, 1'b1} : {device_ff, 1'b0};
               state_in = restart_ff ? ST_ADDR_R : ST_ADDR_W;
               bit_in   = 4'd0;
               phase_in = 2'd0;
            end
         end
         ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R: begin
            if (!bit_ff[3]) begin
               case (phase_ff)
                  2'd1: begin
                     sda_in   = shift_ff[7];
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = 2'd2;
                  end
                  2'd2: begin
                     scl_in   = 1'b1;
                     phase_in = 2'd0;
                     bit_in   = bit_inc;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     phase_in = 2'd1;
                  end
               endcase
            end else begin
               case (phase_ff)
                  2'd0: begin
                     scl_in   = 1'b0;
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     sda_in   = 1'b1;
                     phase_in = 2'd2;
                  end
                  2'd2: begin
                     scl_in   = 1'b1;
                     phase_in = 2'd3;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     phase_in = 2'd0;
                     bit_in   = 4'd0;
                     ack_done = 1'b1;
                  end
               endcase
            end
            if (ack_done) begin
               if (item.sda_level) begin
                  pending_in = STATUS_NO_ACK;
                  state_in   = ST_STOP;
                  phase_in   = 2'd0;
               end else if (state_ff == ST_ADDR_W) begin
                  shift_in = register_ff;
                  state_in = ST_REG;
               end else if (state_ff == ST_REG) begin
                  if (is_read_ff) begin
                     restart_in = 1'b1;
                     state_in   = ST_START_PREP;
                  end else if (left_ff == 8'd0) begin
                     pending_in = STATUS_OK;
                     state_in   = ST_STOP;
                  end else begin
                     req      = 1'b1;
                     state_in = ST_LOAD;
                  end
               end else if (state_ff == ST_DATA) begin
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     pending_in = STATUS_OK;
                     state_in   = ST_STOP;
                  end else begin
                     req      = 1'b1;
                     state_in = ST_LOAD;
                  end
               end else begin
                  if (left_ff == 8'd0) begin
                     pending_in = STATUS_OK;
                     state_in   = ST_STOP;
                  end else begin
                     shift_in = 8'd0;
                     state_in = ST_RECEIVE;
                  end
               end
            end
         end
         ST_LOAD: begin
            shift_in = item.write_byte;
            bit_in   = 4'd0;
            phase_in = 2'd0;
            if (gap_ticks == 16'd0) begin
               state_in = ST_DATA;
            end else begin
               gap_in   = gap_ticks;
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            gap_in = gap_dec;
            if (gap_dec == 16'd0) begin
               state_in = ST_DATA;
            end
         end
         ST_RECEIVE: begin
            if (!bit_ff[3]) begin
               case (phase_ff)
                  2'd1: begin
                     scl_in   = 1'b1;
                     phase_in = 2'd2;
                  end
                  2'd2: begin
                     shift_in = shift_rx;
                     phase_in = 2'd0;
                     bit_in   = bit_inc;
                     if (bit_inc == 4'd8) begin
                        rbyte   = shift_rx;
                        rvalid  = 1'b1;
                        left_in = left_dec;
                     end
                  end
                  default: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = 2'd1;
                  end
               endcase
            end else begin
               case (phase_ff)
                  2'd0: begin
                     scl_in   = 1'b0;
                     sda_in   = (left_ff == 8'd0);
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     scl_in   = 1'b1;
                     phase_in = 2'd2;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     phase_in = 2'd0;
                     bit_in   = 4'd0;
                     shift_in = 8'd0;
                     if (left_ff == 8'd0) begin
                        pending_in = STATUS_OK;
                        state_in   = ST_STOP;
                     end
                  end
               endcase
            end
         end
         ST_STOP: begin
            case (phase_ff)
               2'd0: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  phase_in = 2'd1;
               end
               2'd1: begin
                  scl_in   = 1'b1;
                  phase_in = 2'd2;
               end
               default: begin
                  sda_in   = 1'b1;
                  phase_in = 2'd0;
                  done     = 1'b1;
                  status   = pending_ff;
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
            phase_in = 2'd0;
            bit_in   = 4'd0;
         end
      endcase
   end

   always_comb begin
      result.scl_drive    = scl_in;
      result.sda_drive    = sda_in;
      result.byte_request = req;
      result.read_byte    = rbyte;
      result.read_valid   = rvalid;
      result.busy_res     = (state_in != ST_IDLE);
      result.done_res     = done;
      result.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= 2'd0;
         bit_ff      <= 4'd0;
         shift_ff    <= 8'd0;
         left_ff     <= 8'd0;
         gap_ff      <= 16'd0;
         device_ff   <= 7'd0;
         register_ff <= 8'd0;
         is_read_ff  <= 1'b0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         pending_ff  <= STATUS_OK;
         restart_ff  <= 1'b0;
      end else if (advance) begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         left_ff     <= left_in;
         gap_ff      <= gap_in;
         device_ff   <= device_in;
         register_ff <= register_in;
         is_read_ff  <= is_read_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         pending_ff  <= pending_in;
         restart_ff  <= restart_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_register_access.sv -----
// ----------------------------------------------------------------------------
// I2C master register access
// Stream front end, gap register and result register around the sequencer.
// ----------------------------------------------------------------------------
// Each request beat is one bus phase tick and yields exactly one response
// beat that carries the pin levels and status after that tick. A beat is
// taken every clock cycle when the response side keeps up; each response
// beat passes through the input register and then the result register.
// The gap register is to be written through csr_wr_en and csr_wr_data only
// while no transaction is running; the block itself does not enforce this.
`default_nettype none

module i2c_master_register_access (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // device_address, register_address, byte_count, write_byte, sda_level
   input  wire logic [31:0] req_tdata,
   // action
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // scl_drive, sda_drive, byte_request, read_byte, read_valid, busy_res,
   // done_res, status
   output      logic [15:0] rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import i2cm_pkg::*;

   logic            in_valid_ff;
   tick_item_type   in_item_ff, in_item_in;
   logic            rsp_valid_ff;
   tick_result_type rsp_item_ff, seq_result;
   logic [15:0]     gap_ticks_ff;
   logic            out_free;
   logic            advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.action           = req_tuser;
      in_item_in.device_address   = req_tdata[6:0];
      in_item_in.register_address = req_tdata[14:7];
      in_item_in.byte_count       = req_tdata[22:15];
      in_item_in.write_byte       = req_tdata[30:23];
      in_item_in.sda_level        = req_tdata[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= GAP_TICKS_RESET;
      end else if (csr_wr_en) begin
         gap_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   i2cm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_item_ff),
      .gap_ticks (gap_ticks_ff),
      .result    (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata[0]     = rsp_item_ff.scl_drive;
      rsp_tdata[1]     = rsp_item_ff.sda_drive;
      rsp_tdata[2]     = rsp_item_ff.byte_request;
      rsp_tdata[10:3]  = rsp_item_ff.read_byte;
      rsp_tdata[11]    = rsp_item_ff.read_valid;
      rsp_tdata[12]    = rsp_item_ff.busy_res;
      rsp_tdata[13]    = rsp_item_ff.done_res;
      rsp_tdata[15:14] = rsp_item_ff.status;
   end

endmodule

`default_nettype wire
